// ===== src/speac_pkg.sv =====
// Shared types and constants for the SPI EEPROM access controller.
package speac_pkg;

    // Serial EEPROM instruction codes.
    localparam logic [7:0] OP_WREN  = 8'h06;
    localparam logic [7:0] OP_WRDI  = 8'h04;
    localparam logic [7:0] OP_RDSR  = 8'h05;
    localparam logic [7:0] OP_READ  = 8'h03;
    localparam logic [7:0] OP_WRITE = 8'h02;

    // Request kinds.
    localparam logic [1:0] KIND_READ   = 2'd0;
    localparam logic [1:0] KIND_WRITE  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Frame lengths and the received data byte length, in bits.
    localparam logic [5:0] LEN_LONG  = 6'd32;
    localparam logic [5:0] LEN_SHORT = 6'd16;
    localparam logic [5:0] LEN_OP    = 6'd8;
    localparam logic [5:0] RX_BITS   = 6'd8;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RD       = 4'd1,
        PH_RS       = 4'd2,
        PH_POLL     = 4'd3,
        PH_POLL_GAP = 4'd4,
        PH_WREN     = 4'd5,
        PH_WREN_GAP = 4'd6,
        PH_WR       = 4'd7,
        PH_WR_GAP   = 4'd8,
        PH_WRDI     = 4'd9,
        PH_DONE     = 4'd10
    } t_phase;

    typedef struct packed {
        logic        start_req;
        logic [1:0]  kind;
        logic [10:0] address;
        logic [7:0]  write_data;
        logic        miso;
    } t_in_item;

    typedef struct packed {
        logic       cs_n;
        logic       sclk;
        logic       mosi;
        logic       wp_n;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       wip;
        logic       wel;
        logic [1:0] block_protect;
        logic       srwd;
    } t_out_item;

endpackage

// ===== src/speac_core.sv =====
// Sequencer state and per-tick update logic of the SPI EEPROM access controller.
module speac_core #(
    parameter int ADDR_BITS = 11
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  speac_pkg::t_in_item  i_item,
    output speac_pkg::t_out_item o_res
);

    localparam int AddrW = 11;
    localparam logic [AddrW-1:0] AddrMask =
        (ADDR_BITS >= AddrW) ? {AddrW{1'b1}} : AddrW'((1 << ADDR_BITS) - 1);

    speac_pkg::t_phase r_phase, n_phase;
    logic [5:0]        r_bit_cnt, n_bit_cnt;
    logic              r_half, n_half;
    logic [31:0]       r_out_shift, n_out_shift;
    logic [7:0]        r_in_shift, n_in_shift;
    logic [AddrW-1:0]  r_addr, n_addr;
    logic [7:0]        r_data, n_data;
    logic [7:0]        r_status, n_status;
    logic [7:0]        r_read, n_read;

    logic              rx_frame;
    logic [15:0]       addr_word;
    logic [15:0]       new_addr_word;

    assign rx_frame = (r_phase == speac_pkg::PH_RD) || (r_phase == speac_pkg::PH_RS) ||
                      (r_phase == speac_pkg::PH_POLL);
    assign addr_word     = {{(16 - AddrW){1'b0}}, r_addr & AddrMask};
    assign new_addr_word = {{(16 - AddrW){1'b0}}, i_item.address & AddrMask};

    always_comb begin
        n_phase     = r_phase;
        n_bit_cnt   = r_bit_cnt;
        n_half      = r_half;
        n_out_shift = r_out_shift;
        n_in_shift  = r_in_shift;
        n_addr      = r_addr;
        n_data      = r_data;
        n_status    = r_status;
        n_read      = r_read;

        o_res          = '0;
        o_res.cs_n     = 1'b1;
        o_res.wp_n     = (r_phase == speac_pkg::PH_WREN) ||
                         (r_phase == speac_pkg::PH_WREN_GAP) ||
                         (r_phase == speac_pkg::PH_WR);

        unique case (r_phase)
            speac_pkg::PH_RD, speac_pkg::PH_RS, speac_pkg::PH_POLL,
            speac_pkg::PH_WREN, speac_pkg::PH_WR, speac_pkg::PH_WRDI: begin
                o_res.cs_n     = 1'b0;
                o_res.busy_res = 1'b1;
                o_res.sclk     = ~r_half;
                o_res.mosi     = r_out_shift[31];
                if (!r_half) begin
                    // SCLK high: sample MISO during the data byte of a read frame.
                    if (rx_frame && r_bit_cnt <= speac_pkg::RX_BITS) begin
                        n_in_shift = {r_in_shift[6:0], i_item.miso};
                    end
                    n_half = 1'b1;
                end else begin
                    n_out_shift = {r_out_shift[30:0], 1'b0};
                    n_bit_cnt   = r_bit_cnt - 6'd1;
                    n_half      = 1'b0;
                    if (n_bit_cnt == 6'd0) begin
                        if (rx_frame) begin
                            n_read = r_in_shift;
                        end
                        if (r_phase == speac_pkg::PH_RS || r_phase == speac_pkg::PH_POLL) begin
                            n_status = r_in_shift;
                        end
                        priority case (r_phase)
                            speac_pkg::PH_POLL: n_phase = speac_pkg::PH_POLL_GAP;
                            speac_pkg::PH_WREN: n_phase = speac_pkg::PH_WREN_GAP;
                            speac_pkg::PH_WR:   n_phase = speac_pkg::PH_WR_GAP;
                            default:            n_phase = speac_pkg::PH_DONE;
                        endcase
                    end
                end
            end
            speac_pkg::PH_POLL_GAP: begin
                o_res.busy_res = 1'b1;
                n_half         = 1'b0;
                n_in_shift     = '0;
                if (r_status[0]) begin
                    n_phase     = speac_pkg::PH_POLL;
                    n_out_shift = {speac_pkg::OP_RDSR, 24'd0};
                    n_bit_cnt   = speac_pkg::LEN_SHORT;
                end else begin
                    n_phase     = speac_pkg::PH_WREN;
                    n_out_shift = {speac_pkg::OP_WREN, 24'd0};
                    n_bit_cnt   = speac_pkg::LEN_OP;
                end
            end
            speac_pkg::PH_WREN_GAP: begin
                o_res.busy_res = 1'b1;
                n_phase        = speac_pkg::PH_WR;
                n_out_shift    = {speac_pkg::OP_WRITE, addr_word, r_data};
                n_bit_cnt      = speac_pkg::LEN_LONG;
                n_half         = 1'b0;
                n_in_shift     = '0;
            end
            speac_pkg::PH_WR_GAP: begin
                o_res.busy_res = 1'b1;
                n_phase        = speac_pkg::PH_WRDI;
                n_out_shift    = {speac_pkg::OP_WRDI, 24'd0};
                n_bit_cnt      = speac_pkg::LEN_OP;
                n_half         = 1'b0;
                n_in_shift     = '0;
            end
            speac_pkg::PH_DONE: begin
                o_res.done_res = 1'b1;
                n_phase        = speac_pkg::PH_IDLE;
            end
            default: begin
                // Idle, and any unused phase code, takes a new request.
                n_phase = speac_pkg::PH_IDLE;
                if (i_item.start_req) begin
                    unique case (i_item.kind)
                        speac_pkg::KIND_READ: begin
                            o_res.busy_res = 1'b1;
                            n_phase        = speac_pkg::PH_RD;
                            n_out_shift    = {speac_pkg::OP_READ, new_addr_word, 8'd0};
                            n_bit_cnt      = speac_pkg::LEN_LONG;
                        end
                        speac_pkg::KIND_WRITE: begin
                            o_res.busy_res = 1'b1;
                            n_phase        = speac_pkg::PH_POLL;
                            n_out_shift    = {speac_pkg::OP_RDSR, 24'd0};
                            n_bit_cnt      = speac_pkg::LEN_SHORT;
                        end
                        speac_pkg::KIND_STATUS: begin
                            o_res.busy_res = 1'b1;
                            n_phase        = speac_pkg::PH_RS;
                            n_out_shift    = {speac_pkg::OP_RDSR, 24'd0};
                            n_bit_cnt      = speac_pkg::LEN_SHORT;
                        end
                        default: begin
                        end
                    endcase
                    if (o_res.busy_res) begin
                        n_addr     = i_item.address;
                        n_data     = i_item.write_data;
                        n_half     = 1'b0;
                        n_in_shift = '0;
                    end
                end
            end
        endcase

        o_res.read_data     = n_read;
        o_res.wip           = n_status[0];
        o_res.wel           = n_status[1];
        o_res.block_protect = n_status[3:2];
        o_res.srwd          = n_status[7];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= speac_pkg::PH_IDLE;
            r_bit_cnt   <= '0;
            r_half      <= 1'b0;
            r_out_shift <= '0;
            r_in_shift  <= '0;
            r_addr      <= '0;
            r_data      <= '0;
            r_status    <= '0;
            r_read      <= '0;
        end else if (i_adv) begin
            r_phase     <= n_phase;
            r_bit_cnt   <= n_bit_cnt;
            r_half      <= n_half;
            r_out_shift <= n_out_shift;
            r_in_shift  <= n_in_shift;
            r_addr      <= n_addr;
            r_data      <= n_data;
            r_status    <= n_status;
            r_read      <= n_read;
        end
    end

endmodule

// ===== src/spi_eeprom_access_controller.sv =====
// Top level of the SPI EEPROM access controller: request handshake and result register.
//
// This block is an SPI mode 0 master for a serial EEPROM, driven one tick at a time.
// Every accepted input request is one tick, a half period of SCLK, and yields exactly
// one result: the pin levels for that tick (cs_n, sclk, mosi, wp_n), busy and done
// flags, the last byte received and the fields of the last status byte. A bit takes
// two ticks, SCLK high with MOSI driven and MISO sampled, then SCLK low; bits go most
// significant first and frames are separated by one tick with cs_n high. A start on an
// idle tick latches a read-byte, write-byte or read-status operation; starts while busy
// are ignored. A write polls the status register until WIP clears, then sends WREN,
// WRITE with address and data (wp_n high across both), and finally WRDI. If MISO keeps
// reporting WIP the write polls forever until reset.
// Throughput is one request per clock cycle; each result is registered in the cycle
// after its request, as the tick's state update is a single pass of logic from the
// sequencer registers into the result register. The upstream side is stalled only
// while a result is held in that register and the downstream side stalls it. The
// address is masked to ADDR_BITS before it is sent as a 16-bit field.
module spi_eeprom_access_controller #(
    parameter int ADDR_BITS = 11
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  speac_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output speac_pkg::t_out_item o_out_data
);

    logic                 accept;
    speac_pkg::t_out_item step_res;
    logic                 r_out_valid;
    speac_pkg::t_out_item r_out_data;

    // A new request is taken whenever the result register is empty or being drained.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    speac_core #(
        .ADDR_BITS (ADDR_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (accept),
        .i_item  (i_in_data),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // The result payload needs no reset; it is qualified by the valid flag.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= step_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
